// File: hw/rtl/ptsnm_pkg.sv
// Shared types and constants for the pitch-to-scale note mapper.
`timescale 1ns / 1ps

package ptsnm_pkg;

  // Field widths.
  localparam int PITCH_W     = 15;
  localparam int NOTE_W      = 9;
  localparam int HELD_W      = 64;
  localparam int RND_W       = 8;
  localparam int PC_W        = 4;
  localparam int DIST_W      = 18;
  localparam int IN_TDATA_W  = 144;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SCALE_MODE  = 2'd0;
  localparam logic [1:0] REG_CUSTOM_MASK = 2'd1;
  localparam logic [1:0] REG_KEY_ROOT    = 2'd2;
  localparam logic [1:0] REG_STABILITY   = 2'd3;

  // Scale modes.
  localparam logic [1:0] MODE_MAJOR  = 2'd0;
  localparam logic [1:0] MODE_MINOR  = 2'd1;
  localparam logic [1:0] MODE_CHROM  = 2'd2;
  localparam logic [1:0] MODE_CUSTOM = 2'd3;

  localparam logic [11:0] MASK_MAJOR     = 12'hAB5;
  localparam logic [11:0] MASK_MINOR     = 12'h5AD;
  localparam logic [11:0] MASK_CHROM     = 12'hFFF;
  localparam logic [11:0] CUSTOM_MASK_RST = 12'hFFF;

  // Hysteresis constants: margin = 13 + round(90*s/256), min commit = 1 + round(5*s/256).
  localparam logic [8:0]  STAB_ONE     = 9'd256;
  localparam logic [6:0]  MARGIN_BASE  = 7'd13;
  localparam logic [14:0] MARGIN_GAIN  = 15'd90;
  localparam logic [10:0] COMMIT_GAIN  = 11'd5;
  localparam logic [2:0]  COMMIT_MAX   = 3'd7;

  // Pitch-class arithmetic: x/12 for x < 256 is (x*171) >> 11.
  localparam logic [15:0] RECIP12      = 16'd171;
  localparam int          RECIP12_SH   = 11;
  localparam logic [3:0]  PC_LAST      = 4'd11;
  localparam logic [3:0]  OCTAVE       = 4'd12;
  localparam logic [3:0]  SEARCH_SPAN  = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEARCH,
    ST_DIST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  scale_mode;
    logic [11:0] custom_mask;
    logic [3:0]  key_root;
    logic [8:0]  stability;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic search;
    logic measure;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic voiced;
    logic scan_last;
    logic found;
    logic search_hit;
  } dp_sts_t;

endpackage

// File: hw/rtl/ptsnm_cfg.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module ptsnm_cfg
  import ptsnm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [1:0]  scale_mode_r;
  logic [11:0] custom_mask_r;
  logic [3:0]  key_root_r;
  logic [8:0]  stability_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r  <= MODE_MAJOR;
      custom_mask_r <= CUSTOM_MASK_RST;
      key_root_r    <= 4'd0;
      stability_r   <= 9'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCALE_MODE:  scale_mode_r  <= cfg_pwdata[1:0];
        REG_CUSTOM_MASK: custom_mask_r <= cfg_pwdata[11:0];
        REG_KEY_ROOT:    key_root_r    <= cfg_pwdata[3:0];
        REG_STABILITY:   stability_r   <= cfg_pwdata[8:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCALE_MODE:  cfg_prdata = {30'd0, scale_mode_r};
      REG_CUSTOM_MASK: cfg_prdata = {20'd0, custom_mask_r};
      REG_KEY_ROOT:    cfg_prdata = {28'd0, key_root_r};
      REG_STABILITY:   cfg_prdata = {23'd0, stability_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.scale_mode  = scale_mode_r;
  assign cfg.custom_mask = custom_mask_r;
  assign cfg.key_root    = key_root_r;
  assign cfg.stability   = stability_r;

endmodule

// File: hw/rtl/ptsnm_ctrl.sv
// Sequencer for the note mapper: scan, scale search, distance and commit steps.
`timescale 1ns / 1ps

module ptsnm_ctrl
  import ptsnm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.voiced) state_nxt = ST_EMIT;
        else if (sts.scan_last) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.found || sts.search_hit) state_nxt = ST_DIST;
      end
      ST_DIST: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN:   cmd.scan    = sts.voiced;
      ST_SEARCH: cmd.search  = !sts.found;
      ST_DIST:   cmd.measure = 1'b1;
      ST_EMIT:   cmd.emit    = slot_free;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result written over a word not yet taken");
  a_scan_to_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && sts.voiced && sts.scan_last) |=> state_r == ST_SEARCH)
    else $error("scan did not hand over to the scale search");
  a_search_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && !sts.found) |-> (sts.search_hit || !cmd.emit))
    else $error("emit issued during the scale search");
`endif

endmodule

// File: hw/rtl/ptsnm_dp.sv
// Datapath of the note mapper: held-note scan, scale search and target update.
`timescale 1ns / 1ps

module ptsnm_dp
  import ptsnm_pkg::*;
#(
  parameter int NOTE_COUNT = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  cfg_t                     cfg,
  input  logic [IN_TDATA_W-1:0]    in_tdata,
  input  logic [IN_TUSER_W-1:0]    in_tuser,
  output logic signed [NOTE_W-1:0] out_target
);

  localparam int CW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

  logic [PITCH_W-1:0]       pitch_r;
  logic                     voiced_r;
  logic                     onset_r;
  logic [NOTE_COUNT-1:0]    held_r;
  logic [RND_W-1:0]         rnd_r;
  logic signed [16:0]       diff_r;
  logic [15:0]              best_r;
  logic [CW-1:0]            n_r;
  logic                     found_r;
  logic signed [NOTE_W-1:0] prop_r;
  logic signed [NOTE_W-1:0] cand_dn_r, cand_up_r;
  logic [PC_W-1:0]          pc_dn_r, pc_up_r;
  logic [3:0]               d_r;
  logic [DIST_W-2:0]        dcur_r, dprop_r;
  logic signed [NOTE_W-1:0] target_r, target_nxt;
  logic [2:0]               commit_r, commit_nxt;
  logic signed [NOTE_W-1:0] out_target_r;

  logic [2*HELD_W-1:0]      held_all;
  logic [15:0]              scan_abs;
  logic                     scan_take;
  logic [15:0]              rnd_prod;
  logic [4:0]               rnd_q;
  logic [PC_W-1:0]          rnd_pc, key_pc, pc0;
  logic [11:0]              mask;
  logic                     dn_hit, up_hit;
  logic signed [NOTE_W-1:0] rnd_note, search_pick;
  logic [8:0]               stab_sat;
  logic [14:0]              margin_prod;
  logic [10:0]              commit_prod;
  logic [6:0]               margin;
  logic [2:0]               min_commit;
  logic signed [DIST_W-1:0] pitch_ext, cur_diff, prop_diff;
  logic [DIST_W-2:0]        cur_abs, prop_abs;
  logic                     closer, change;

  assign held_all = {in_tdata[PITCH_W+2*HELD_W-1:PITCH_W+HELD_W],
                     in_tdata[PITCH_W+HELD_W-1:PITCH_W]};

  // Held-note scan: one note per cycle, strict compare keeps the lower note on a tie.
  assign scan_abs  = diff_r[16] ? 16'(-diff_r) : diff_r[15:0];
  assign scan_take = held_r[0] && (scan_abs < best_r);

  // Pitch class of the rounded pitch relative to the key root.
  assign rnd_prod = 16'(rnd_r) * RECIP12;
  assign rnd_q    = rnd_prod[15:RECIP12_SH];
  assign rnd_pc   = PC_W'(rnd_r - 8'(rnd_q) * 8'(OCTAVE));
  assign key_pc   = (cfg.key_root >= OCTAVE) ? cfg.key_root - OCTAVE : cfg.key_root;
  assign pc0      = (rnd_pc >= key_pc) ? rnd_pc - key_pc : rnd_pc + OCTAVE - key_pc;
  assign rnd_note = NOTE_W'(rnd_r);

  always_comb begin
    case (cfg.scale_mode)
      MODE_MAJOR: mask = MASK_MAJOR;
      MODE_MINOR: mask = MASK_MINOR;
      MODE_CHROM: mask = MASK_CHROM;
      default:    mask = cfg.custom_mask;
    endcase
  end

  assign dn_hit = mask[pc_dn_r];
  assign up_hit = mask[pc_up_r] && (d_r != 4'd0);
  assign search_pick = dn_hit ? cand_dn_r : (up_hit ? cand_up_r : rnd_note);

  // Hysteresis from the stability register.
  assign stab_sat    = (cfg.stability > STAB_ONE) ? STAB_ONE : cfg.stability;
  assign margin_prod = 15'(stab_sat) * MARGIN_GAIN + 15'd128;
  assign commit_prod = 11'(stab_sat) * COMMIT_GAIN + 11'd128;
  assign margin      = MARGIN_BASE + margin_prod[14:8];
  assign min_commit  = 3'd1 + commit_prod[10:8];

  assign pitch_ext = DIST_W'(pitch_r);
  assign cur_diff  = pitch_ext - {target_r[NOTE_W-1], target_r, 8'd0};
  assign prop_diff = pitch_ext - {prop_r[NOTE_W-1], prop_r, 8'd0};
  assign cur_abs   = cur_diff[DIST_W-1] ? (DIST_W-1)'(-cur_diff) : cur_diff[DIST_W-2:0];
  assign prop_abs  = prop_diff[DIST_W-1] ? (DIST_W-1)'(-prop_diff) : prop_diff[DIST_W-2:0];

  assign closer = ({1'b0, dprop_r} + DIST_W'(margin)) < {1'b0, dcur_r};
  assign change = target_r[NOTE_W-1] ||
                  ((prop_r != target_r) &&
                   (onset_r || ((commit_r >= min_commit) && closer)));

  always_comb begin
    target_nxt = target_r;
    commit_nxt = commit_r;
    if (change) begin
      target_nxt = prop_r;
      commit_nxt = 3'd1;
    end else if (commit_r < COMMIT_MAX) begin
      commit_nxt = commit_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pitch_r  <= in_tdata[PITCH_W-1:0];
      voiced_r <= in_tuser[0];
      onset_r  <= in_tuser[1];
      held_r   <= held_all[NOTE_COUNT-1:0];
      rnd_r    <= RND_W'((16'(in_tdata[PITCH_W-1:0]) + 16'd128) >> 8);
      diff_r   <= 17'(in_tdata[PITCH_W-1:0]);
      best_r   <= '1;
      n_r      <= '0;
      found_r  <= 1'b0;
    end
    if (cmd.scan) begin
      if (scan_take) begin
        best_r  <= scan_abs;
        prop_r  <= NOTE_W'(n_r);
        found_r <= 1'b1;
      end
      held_r    <= held_r >> 1;
      diff_r    <= diff_r - 17'sd256;
      n_r       <= n_r + 1'b1;
      cand_dn_r <= rnd_note;
      cand_up_r <= rnd_note;
      pc_dn_r   <= pc0;
      pc_up_r   <= pc0;
      d_r       <= 4'd0;
    end
    if (cmd.search) begin
      if (dn_hit || up_hit || d_r == SEARCH_SPAN) prop_r <= search_pick;
      cand_dn_r <= cand_dn_r - 9'sd1;
      cand_up_r <= cand_up_r + 9'sd1;
      pc_dn_r   <= (pc_dn_r == 4'd0) ? PC_LAST : pc_dn_r - 4'd1;
      pc_up_r   <= (pc_up_r == PC_LAST) ? 4'd0 : pc_up_r + 4'd1;
      d_r       <= d_r + 4'd1;
    end
    if (cmd.measure) begin
      dcur_r  <= cur_abs;
      dprop_r <= prop_abs;
    end
    if (cmd.emit) begin
      out_target_r <= voiced_r ? target_nxt : target_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= -9'sd1;
      commit_r <= 3'd0;
    end else if (cmd.emit && voiced_r) begin
      target_r <= target_nxt;
      commit_r <= commit_nxt;
    end
  end

  assign sts.voiced     = voiced_r;
  assign sts.scan_last  = (n_r == CW'(NOTE_COUNT - 1));
  assign sts.found      = found_r;
  assign sts.search_hit = dn_hit || up_hit || (d_r == SEARCH_SPAN);
  assign out_target     = out_target_r;

`ifndef ASSERT_OFF
  a_commit_after_target: assert property (@(posedge clk) disable iff (!rst_n)
    !target_r[NOTE_W-1] |-> commit_r != 3'd0)
    else $error("target held with a zero commit count");
  a_first_take: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && voiced_r && target_r[NOTE_W-1]) |=> (commit_r == 3'd1))
    else $error("first proposal did not reset the commit count");
`endif

endmodule

// File: hw/rtl/pitch_to_scale_note_mapper.sv
// Top level of the pitch-to-scale note mapper.
`timescale 1ns / 1ps

// Each input word is one analysis frame: in_tuser carries voiced and onset,
// in_tdata the Q7.8 pitch and the 128-bit held-note set. Every frame yields
// exactly one output word holding the current target note (signed) in
// out_tdata and a has-target flag in out_tuser.
// A voiced frame walks the held-note set one note per cycle, then passes
// through the search step if a note was held, or else searches the
// scale outward from the rounded pitch one distance per cycle, up to
// twelve semitones away; the distance compare and the commit follow. An
// unvoiced frame goes from the scan straight to the commit. The controller
// returns to idle before it takes the next frame, so a new frame waits
// until the last is through, and the held-note scan sets the rate.
// The result sits in an output register, so a new frame is accepted while
// the previous word waits; if the receiver stalls, the next frame finishes
// its work and then holds until the output register is free.
// Reset clears the target (reported as -1, no target), the commit counter
// and the configuration registers to their defaults; no clearing pass.
// Configuration is to be written through the APB-style port only while
// idle; the block itself does not enforce this.

module pitch_to_scale_note_mapper
  import ptsnm_pkg::*;
#(
  parameter int NOTE_COUNT = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pitch[14:0], held_notes_low[78:15], held_notes_high[142:79], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // voiced[0], onset[1]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // target_note[8:0] (signed), zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // has_target[0]
  output logic [0:0]             out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t                     cfg;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;
  logic signed [NOTE_W-1:0] target;

  ptsnm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ptsnm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ptsnm_dp #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_target (target)
  );

  // A negative target means none is held.
  assign out_tdata    = {{(OUT_TDATA_W - NOTE_W){1'b0}}, target};
  assign out_tuser[0] = !target[NOTE_W-1];

endmodule

// File: bench/pitch_to_scale_note_mapper_tb.sv
// Self-checking testbench for the pitch-to-scale note mapper.
`timescale 1ns / 1ps

module pitch_to_scale_note_mapper_tb;
  import ptsnm_pkg::*;

  // One analysis frame as the stimulus side sees it.
  typedef struct packed {
    logic               voiced;
    logic               onset;
    logic [PITCH_W-1:0] pitch;
    logic [127:0]       held;
  } frame_t;

  // One result word: the fields carried on out_tuser and out_tdata.
  typedef struct packed {
    logic                     has_target;
    logic signed [NOTE_W-1:0] note;
  } note_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // pitch[14:0], held_notes_low[78:15], held_notes_high[142:79], zero pad
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // voiced[0], onset[1]
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // target_note[8:0] (signed), zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  // has_target[0]
  logic [0:0]             out_tuser;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // Mirror of the block's registers and tracking state, at their reset values.
  logic [1:0]  cfg_mode   = MODE_MAJOR;
  logic [11:0] cfg_custom = CUSTOM_MASK_RST;
  logic [3:0]  cfg_key    = 4'd0;
  logic [8:0]  cfg_stab   = 9'd0;
  int          target_q   = -1;
  int          commit_q   = 0;

  // Results owed by the block, oldest first.
  note_word_t pending_notes[$];
  note_word_t due_word;
  int         mismatch_count = 0;

  // Idling controls, in percent: sender gaps and receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Random pitch walk shared across frames so that hysteresis gets exercised.
  int walk_pitch = 60 * 256;

  pitch_to_scale_note_mapper u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The run is bounded by a fixed time well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    end
  endfunction

  // Pitch class of a note relative to the key root; a root above 11 wraps.
  function automatic int pitch_class(input int note);
    return ((note - int'(cfg_key)) % 12 + 12) % 12;
  endfunction

  function automatic int abs_dist(input int pitch, input int note);
    int d;
    d = pitch - note * 256;
    return (d < 0) ? -d : d;
  endfunction

  // Outward search from the rounded pitch, down before up, up to an octave away.
  // With an empty mask nothing matches and the rounded pitch stands.
  function automatic int nearest_scale_note(input int rounded);
    logic [11:0] mask;
    case (cfg_mode)
      MODE_MAJOR: mask = MASK_MAJOR;
      MODE_MINOR: mask = MASK_MINOR;
      MODE_CHROM: mask = MASK_CHROM;
      default:    mask = cfg_custom;
    endcase
    for (int d = 0; d <= 12; d++) begin
      if (mask[pitch_class(rounded - d)]) return rounded - d;
      if (d > 0 && mask[pitch_class(rounded + d)]) return rounded + d;
    end
    return rounded;
  endfunction

  // Applies one accepted frame to the tracked state and returns the word it yields.
  function automatic note_word_t advance_target(input frame_t f);
    int         p;
    int         proposed;
    int         best;
    int         span;
    int         s;
    int         margin;
    int         min_commit;
    note_word_t w;
    if (f.voiced) begin
      p        = int'(f.pitch);
      proposed = -1;
      best     = 32'h7FFF_FFFF;
      // Nearest held note; the strict compare lets the lower note win a tie.
      for (int n = 0; n < 128; n++) begin
        span = abs_dist(p, n);
        if (f.held[n] && span < best) begin
          best     = span;
          proposed = n;
        end
      end
      if (proposed < 0) proposed = nearest_scale_note((p + 128) >> 8);
      if (target_q < 0) begin
        // No target yet: the proposal is taken at once, even a negative one.
        target_q = proposed;
        commit_q = 1;
      end else begin
        s          = (cfg_stab > STAB_ONE) ? 256 : int'(cfg_stab);
        margin     = 13 + ((90 * s + 128) >> 8);
        min_commit = 1 + ((5 * s + 128) >> 8);
        if (proposed != target_q &&
            (f.onset || (commit_q >= min_commit &&
                         abs_dist(p, proposed) + margin < abs_dist(p, target_q)))) begin
          target_q = proposed;
          commit_q = 1;
        end else if (commit_q < 7) begin
          commit_q++;
        end
      end
    end
    w.has_target = (target_q >= 0);
    w.note       = target_q[NOTE_W-1:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every word taken by the receiver is matched against the
  // oldest pending prediction, one field at a time.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_notes.size() == 0) begin
        note_failure("word with nothing pending", 0,
                     int'($signed(out_tdata[NOTE_W-1:0])));
      end else begin
        due_word = pending_notes.pop_front();
        if (out_tuser[0] !== due_word.has_target) begin
          note_failure("has_target", int'(due_word.has_target), int'(out_tuser[0]));
        end
        if (out_tdata[NOTE_W-1:0] !== due_word.note) begin
          note_failure("target_note", int'(due_word.note),
                       int'($signed(out_tdata[NOTE_W-1:0])));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. Every task starts and ends on a falling edge.
  // ---------------------------------------------------------------------------

  function automatic frame_t make_frame(input logic voiced, input logic onset,
                                        input logic [PITCH_W-1:0] pitch,
                                        input logic [127:0] held);
    frame_t f;
    f.voiced = voiced;
    f.onset  = onset;
    f.pitch  = pitch;
    f.held   = held;
    return f;
  endfunction

  // Presents one frame, holds it until accepted, then records its prediction.
  // The valid stays high on return so back-to-back frames leave no bubble.
  task automatic send_frame(input frame_t f);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      // Mostly short gaps, now and then one long enough to span a whole scan.
      gap = ($urandom_range(3) == 0) ? $urandom_range(160, 1) : $urandom_range(4, 1);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {1'b0, f.held, f.pitch};
    in_tuser  = {f.onset, f.voiced};
    do @(posedge clk); while (!in_tready);
    pending_notes.push_back(advance_target(f));
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted word has come back. Each frame
  // yields one word, so the block is idle once nothing is pending.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_notes.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_SCALE_MODE:  cfg_mode   = value[1:0];
      REG_CUSTOM_MASK: cfg_custom = value[11:0];
      REG_KEY_ROOT:    cfg_key    = value[3:0];
      default:         cfg_stab   = value[8:0];
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [CFG_DW-1:0] want;
    case (idx)
      REG_SCALE_MODE:  want = CFG_DW'(cfg_mode);
      REG_CUSTOM_MASK: want = CFG_DW'(cfg_custom);
      REG_KEY_ROOT:    want = CFG_DW'(cfg_key);
      default:         want = CFG_DW'(cfg_stab);
    endcase
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b0;
    cfg_paddr  = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) note_failure("register read", want, cfg_prdata);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_all_regs();
    check_reg(REG_SCALE_MODE);
    check_reg(REG_CUSTOM_MASK);
    check_reg(REG_KEY_ROOT);
    check_reg(REG_STABILITY);
  endtask

  task automatic apply_tuning(input logic [1:0] mode, input logic [11:0] mask,
                              input logic [3:0] key, input logic [8:0] stab);
    wait_idle();
    write_reg(REG_SCALE_MODE, CFG_DW'(mode));
    write_reg(REG_CUSTOM_MASK, CFG_DW'(mask));
    write_reg(REG_KEY_ROOT, CFG_DW'(key));
    write_reg(REG_STABILITY, CFG_DW'(stab));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers, and no target before any voiced frame.
  task automatic test_after_reset();
    check_all_regs();
    send_frame(make_frame(1'b0, 1'b0, 15'h7FFF, '0));
    wait_idle();
  endtask

  // Every register takes all ones (upper data bits must be dropped) and zero.
  task automatic test_register_access();
    write_reg(REG_SCALE_MODE, '1);
    write_reg(REG_CUSTOM_MASK, '1);
    write_reg(REG_KEY_ROOT, '1);
    write_reg(REG_STABILITY, '1);
    check_all_regs();
    apply_tuning(MODE_MAJOR, 12'h000, 4'd0, 9'd0);
    check_all_regs();
  endtask

  task automatic test_directed_frames();
    apply_tuning(MODE_MAJOR, CUSTOM_MASK_RST, 4'd0, 9'd0);
    // First voiced frame sets the target; C sharp then snaps back to C.
    send_frame(make_frame(1'b1, 1'b0, 15'(60 * 256), '0));
    send_frame(make_frame(1'b1, 1'b0, 15'(61 * 256), '0));
    // Pitch extremes with no held notes move the target by distance alone.
    send_frame(make_frame(1'b1, 1'b0, 15'd0, '0));
    send_frame(make_frame(1'b1, 1'b0, 15'h7FFF, '0));
    // Held notes at both ends of the set, forced in by an onset.
    send_frame(make_frame(1'b1, 1'b1, 15'h7FFF, 128'd1));
    send_frame(make_frame(1'b1, 1'b1, 15'd0, 128'd1 << 127));
    // Equal distance to two held notes: the lower one wins.
    send_frame(make_frame(1'b1, 1'b1, 15'(61 * 256), (128'd1 << 60) | (128'd1 << 62)));
    send_frame(make_frame(1'b1, 1'b1, 15'(70 * 256 + 127), '1));
    // Exactly half a semitone rounds up.
    send_frame(make_frame(1'b1, 1'b0, 15'(64 * 256 + 128), '0));
    // An unvoiced frame ignores its onset and held notes.
    send_frame(make_frame(1'b0, 1'b1, 15'd0, '1));

    // Only pitch class 11 in scale: from the bottom the search lands below
    // note 0, read as no target; the next frame does too; the third replaces it.
    apply_tuning(MODE_CUSTOM, 12'h800, 4'd0, 9'd0);
    send_frame(make_frame(1'b1, 1'b1, 15'd0, '0));
    send_frame(make_frame(1'b1, 1'b0, 15'(5 * 256), '0));
    send_frame(make_frame(1'b1, 1'b0, 15'(12 * 256), '0));

    // Empty mask: the rounded pitch itself is proposed.
    apply_tuning(MODE_CUSTOM, 12'h000, 4'd0, 9'd0);
    send_frame(make_frame(1'b1, 1'b1, 15'(40 * 256 + 100), '0));

    // Root above 11 wraps, stability above one is clipped; the commit count
    // climbs over steady frames until the target moves; a far jump is then held.
    apply_tuning(MODE_MAJOR, 12'h000, 4'd15, 9'd511);
    repeat (8) send_frame(make_frame(1'b1, 1'b0, 15'(50 * 256), '0));
    send_frame(make_frame(1'b1, 1'b0, 15'(57 * 256), '0));

    apply_tuning(MODE_MINOR, 12'h000, 4'd11, STAB_ONE);
    send_frame(make_frame(1'b1, 1'b1, 15'(66 * 256), '0));
    apply_tuning(MODE_CHROM, 12'h000, 4'd0, 9'd128);
    send_frame(make_frame(1'b1, 1'b0, 15'(67 * 256 + 200), '0));
  endtask

  // One idling phase of random frames over four register settings. Most frames
  // follow a slow pitch walk so that hysteresis and the commit count matter;
  // the rest jump or sit near a range end or rounding edge; half carry held notes.
  task automatic test_random_frames(input int send_pct, input int stall_pct,
                                    input logic [1:0] phase_mode);
    frame_t fr;
    int     step;
    int     note;
    wait_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: apply_tuning(MODE_MAJOR, 12'h000, 4'd0, 9'd0);
        1: apply_tuning(MODE_CUSTOM, 12'hFFF, 4'd15, 9'd511);
        2: apply_tuning(phase_mode, 12'($urandom), 4'($urandom_range(15)), STAB_ONE);
        default: apply_tuning(2'($urandom),
                              ($urandom_range(3) == 0) ? 12'h000 : 12'($urandom),
                              4'($urandom_range(15)), 9'($urandom));
      endcase
      for (int i = 0; i < 85; i++) begin
        fr.voiced = ($urandom_range(9) != 0);
        fr.onset  = ($urandom_range(7) == 0);
        case ($urandom_range(9))
          0: walk_pitch = $urandom_range(32767);
          1: walk_pitch = $urandom_range(1) ? 32767 - $urandom_range(300)
                                            : $urandom_range(300);
          2: walk_pitch = $urandom_range(100, 20) * 256 + $urandom_range(255);
          // Near the rounding boundary of the current semitone.
          3: walk_pitch = (walk_pitch & 32'h7F00) + 124 + $urandom_range(8);
          default: begin
            step       = int'($urandom_range(1536)) - 768;
            walk_pitch = walk_pitch + step;
          end
        endcase
        if (walk_pitch < 0) walk_pitch = 0;
        if (walk_pitch > 32767) walk_pitch = 32767;
        fr.pitch = walk_pitch[PITCH_W-1:0];
        case ($urandom_range(9))
          5, 6, 7: begin
            fr.held = '0;
            repeat ($urandom_range(3, 1)) begin
              note = (walk_pitch >> 8) + int'($urandom_range(12)) - 6;
              if (note < 0) note = 0;
              if (note > 127) note = 127;
              fr.held[note] = 1'b1;
            end
          end
          8:       fr.held = {$urandom, $urandom, $urandom, $urandom};
          9:       fr.held = $urandom_range(1) ? '1 : (128'd1 << $urandom_range(127));
          default: fr.held = '0;
        endcase
        send_frame(fr);
        // Now and then let the block run completely dry mid-stream.
        if ($urandom_range(63) == 0) wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_after_reset();
    test_register_access();
    test_directed_frames();
    test_random_frames(0, 0, MODE_MINOR);
    test_random_frames(70, 0, MODE_CHROM);
    test_random_frames(0, 70, MODE_CUSTOM);
    test_random_frames(35, 35, MODE_MAJOR);
    wait_idle();
    // Wait long past the slowest frame, so anything stray shows up by now.
    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && pending_notes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
